>>> hw/rtl/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
// Holds command codes, register indexes, phase encoding and the config struct.
// No dependencies.
package owbm_pkg;

    localparam int COUNT_BITS_DEF = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 10;
    localparam int LIM_W          = 10;

    typedef enum logic [1:0] {
        FUNC_NONE  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_TMO    = 3'd1,
        REG_SHORT_PULSE = 3'd2,
        REG_LONG_PULSE  = 3'd3,
        REG_SAMPLE_DLY  = 3'd4
    } t_reg_idx;

    localparam logic [9:0] RESET_LOW_DEF   = 10'd480;
    localparam logic [9:0] PRES_TMO_DEF    = 10'd500;
    localparam logic [3:0] SHORT_PULSE_DEF = 4'd2;
    localparam logic [6:0] LONG_PULSE_DEF  = 7'd60;
    localparam logic [5:0] SAMPLE_DLY_DEF  = 6'd7;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [9:0] presence_timeout;
        logic [3:0] short_pulse_ticks;
        logic [6:0] long_pulse_ticks;
        logic [5:0] sample_delay_ticks;
    } t_cfg;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_RST_LOW   = 9'b000000010,
        PH_WAIT_LOW  = 9'b000000100,
        PH_WAIT_HIGH = 9'b000001000,
        PH_WR_LOW    = 9'b000010000,
        PH_WR_REL    = 9'b000100000,
        PH_RD_LOW    = 9'b001000000,
        PH_RD_WAIT   = 9'b010000000,
        PH_RD_REST   = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_device;
        logic [7:0] rx_byte;
    } t_result;

endpackage

>>> hw/rtl/owbm_cfg.sv
// Configuration register file for the one-wire bus master.
// Depends on owbm_pkg for register indexes, reset values and the t_cfg struct.
module owbm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output owbm_pkg::t_cfg                   o_cfg
);

    owbm_pkg::t_cfg r_cfg;
    owbm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (owbm_pkg::t_reg_idx'(i_wr_index))
                owbm_pkg::REG_RESET_LOW:   n_cfg.reset_low_ticks    = i_wr_data[9:0];
                owbm_pkg::REG_PRES_TMO:    n_cfg.presence_timeout   = i_wr_data[9:0];
                owbm_pkg::REG_SHORT_PULSE: n_cfg.short_pulse_ticks  = i_wr_data[3:0];
                owbm_pkg::REG_LONG_PULSE:  n_cfg.long_pulse_ticks   = i_wr_data[6:0];
                owbm_pkg::REG_SAMPLE_DLY:  n_cfg.sample_delay_ticks = i_wr_data[5:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks    <= owbm_pkg::RESET_LOW_DEF;
            r_cfg.presence_timeout   <= owbm_pkg::PRES_TMO_DEF;
            r_cfg.short_pulse_ticks  <= owbm_pkg::SHORT_PULSE_DEF;
            r_cfg.long_pulse_ticks   <= owbm_pkg::LONG_PULSE_DEF;
            r_cfg.sample_delay_ticks <= owbm_pkg::SAMPLE_DLY_DEF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/owbm_core.sv
// Bus sequencing state and per-tick step logic of the one-wire bus master.
// Depends on owbm_pkg for the phase encoding, command codes and structs.
module owbm_core #(
    parameter int COUNT_BITS = owbm_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_tx_byte,
    input  logic               i_line_level,
    input  owbm_pkg::t_cfg     i_cfg,
    output owbm_pkg::t_result  o_res
);

    localparam int CMP_W = (COUNT_BITS > owbm_pkg::LIM_W) ? COUNT_BITS : owbm_pkg::LIM_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    owbm_pkg::t_phase         r_phase, n_phase, ph;
    logic [COUNT_BITS-1:0]    r_tick, n_tick, tc, tc_inc;
    logic [2:0]               r_bit_idx, n_bit_idx, bi;
    logic [7:0]               r_shift, n_shift, sb;
    logic [7:0]               r_rx, n_rx;
    logic [owbm_pkg::LIM_W-1:0] lim;
    logic                     cur_bit;
    logic                     reached;
    logic                     drive;
    logic                     done;
    logic                     nodev;

    always_comb begin
        ph = r_phase;
        tc = r_tick;
        bi = r_bit_idx;
        sb = r_shift;
        if (r_phase == owbm_pkg::PH_IDLE && owbm_pkg::t_func'(i_func) != owbm_pkg::FUNC_NONE) begin
            bi = 3'd0;
            tc = '0;
            case (owbm_pkg::t_func'(i_func))
                owbm_pkg::FUNC_RESET: begin
                    ph = owbm_pkg::PH_RST_LOW;
                    sb = 8'd0;
                end
                owbm_pkg::FUNC_WRITE: begin
                    ph = owbm_pkg::PH_WR_LOW;
                    sb = i_tx_byte;
                end
                default: begin
                    ph = owbm_pkg::PH_RD_LOW;
                    sb = 8'd0;
                end
            endcase
        end

        drive   = (ph == owbm_pkg::PH_RST_LOW) || (ph == owbm_pkg::PH_WR_LOW) ||
                  (ph == owbm_pkg::PH_RD_LOW);
        cur_bit = sb[bi];

        case (ph)
            owbm_pkg::PH_RST_LOW:   lim = i_cfg.reset_low_ticks;
            owbm_pkg::PH_WAIT_LOW,
            owbm_pkg::PH_WAIT_HIGH: lim = i_cfg.presence_timeout;
            owbm_pkg::PH_WR_LOW:    lim = cur_bit ? 10'(i_cfg.short_pulse_ticks)
                                                  : 10'(i_cfg.long_pulse_ticks);
            owbm_pkg::PH_WR_REL:    lim = cur_bit ? 10'(i_cfg.long_pulse_ticks)
                                                  : 10'(i_cfg.short_pulse_ticks);
            owbm_pkg::PH_RD_LOW:    lim = 10'(i_cfg.short_pulse_ticks);
            owbm_pkg::PH_RD_WAIT:   lim = 10'(i_cfg.sample_delay_ticks);
            owbm_pkg::PH_RD_REST:   lim = 10'(i_cfg.long_pulse_ticks);
            default:                lim = '0;
        endcase

        tc_inc  = (tc == CNT_MAX) ? tc : tc + 1'b1;
        reached = (tc_inc == CNT_MAX) || (CMP_W'(tc_inc) >= CMP_W'(lim));

        n_phase   = ph;
        n_tick    = tc;
        n_bit_idx = bi;
        n_shift   = sb;
        n_rx      = r_rx;
        done      = 1'b0;
        nodev     = 1'b0;

        case (ph)
            owbm_pkg::PH_IDLE: begin
                n_phase = owbm_pkg::PH_IDLE;
            end
            owbm_pkg::PH_RST_LOW: begin
                n_tick = tc_inc;
                if (reached) begin
                    n_phase = owbm_pkg::PH_WAIT_LOW;
                    n_tick  = '0;
                end
            end
            owbm_pkg::PH_WAIT_LOW: begin
                if (!i_line_level) begin
                    n_phase = owbm_pkg::PH_WAIT_HIGH;
                    n_tick  = '0;
                end else begin
                    n_tick = tc_inc;
                    if (reached) begin
                        done  = 1'b1;
                        nodev = 1'b1;
                    end
                end
            end
            owbm_pkg::PH_WAIT_HIGH: begin
                if (i_line_level) begin
                    done = 1'b1;
                end else begin
                    n_tick = tc_inc;
                    if (reached) begin
                        done  = 1'b1;
                        nodev = 1'b1;
                    end
                end
            end
            owbm_pkg::PH_WR_LOW: begin
                n_tick = tc_inc;
                if (reached) begin
                    n_phase = owbm_pkg::PH_WR_REL;
                    n_tick  = '0;
                end
            end
            owbm_pkg::PH_WR_REL: begin
                n_tick = tc_inc;
                if (reached) begin
                    if (bi == 3'd7) begin
                        done = 1'b1;
                    end else begin
                        n_bit_idx = bi + 3'd1;
                        n_phase   = owbm_pkg::PH_WR_LOW;
                        n_tick    = '0;
                    end
                end
            end
            owbm_pkg::PH_RD_LOW: begin
                n_tick = tc_inc;
                if (reached) begin
                    n_phase = owbm_pkg::PH_RD_WAIT;
                    n_tick  = '0;
                end
            end
            owbm_pkg::PH_RD_WAIT: begin
                n_tick = tc_inc;
                if (reached) begin
                    n_shift     = sb;
                    n_shift[bi] = sb[bi] | i_line_level;
                    n_phase     = owbm_pkg::PH_RD_REST;
                    n_tick      = '0;
                end
            end
            owbm_pkg::PH_RD_REST: begin
                n_tick = tc_inc;
                if (reached) begin
                    if (bi == 3'd7) begin
                        n_rx = sb;
                        done = 1'b1;
                    end else begin
                        n_bit_idx = bi + 3'd1;
                        n_phase   = owbm_pkg::PH_RD_LOW;
                        n_tick    = '0;
                    end
                end
            end
            default: begin
                n_phase = owbm_pkg::PH_IDLE;
            end
        endcase

        if (done) begin
            n_phase   = owbm_pkg::PH_IDLE;
            n_tick    = '0;
            n_bit_idx = 3'd0;
        end

        o_res.drive_low = drive;
        o_res.busy_res  = (n_phase != owbm_pkg::PH_IDLE);
        o_res.done_res  = done;
        o_res.no_device = nodev;
        o_res.rx_byte   = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= owbm_pkg::PH_IDLE;
            r_tick    <= '0;
            r_bit_idx <= 3'd0;
            r_shift   <= 8'd0;
            r_rx      <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_rx      <= n_rx;
        end
    end

endmodule

>>> hw/rtl/one_wire_bus_master_unit.sv
// Top level of the one-wire bus master: input register, step core, result register.
// Depends on owbm_pkg, owbm_cfg and owbm_core.
//
//  Channel  Direction  Handshake                 Payload
//  in       sink       i_in_valid / o_in_ready   i_func, i_tx_byte, i_line_level
//  out      source     o_out_valid / i_out_ready o_drive_low, o_busy_res, o_done_res,
//                                                o_no_device, o_rx_byte
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each tick transaction passes through the input register and then the result register,
// and one transaction is taken every cycle while the output side does not stall.
// The step core updates its sequencing state when a tick moves into the result register.
// A stall on the output side holds both registers; the input side stalls only when both
// are full. Reset is synchronous and active low and clears all control state.
module one_wire_bus_master_unit #(
    parameter int COUNT_BITS = owbm_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [7:0]                      i_tx_byte,
    input  logic                            i_line_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_drive_low,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic                            o_no_device,
    output logic [7:0]                      o_rx_byte,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic [1:0]         r_func;
    logic [7:0]         r_tx_byte;
    logic               r_line_level;
    logic               r_out_valid;
    owbm_pkg::t_result  r_res;
    owbm_pkg::t_result  step_res;
    owbm_pkg::t_cfg     cfg;
    logic               advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    owbm_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_func       (r_func),
        .i_tx_byte    (r_tx_byte),
        .i_line_level (r_line_level),
        .i_cfg        (cfg),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func       <= i_func;
            r_tx_byte    <= i_tx_byte;
            r_line_level <= i_line_level;
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_res.drive_low;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_no_device = r_res.no_device;
    assign o_rx_byte   = r_res.rx_byte;

    a_nodev_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_device) |-> o_done_res)
        else $error("Missing-device flag raised without command completion.");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (!o_busy_res && !o_drive_low))
        else $error("Completion tick shows busy or a driven line.");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_res)))
        else $error("Stalled result changed inside the block.");

endmodule

>>> verif/owbm_tick_checker.sv
`timescale 1ns / 1ps
// Checker for the one-wire bus master: watches the tick, result and register channels.
// Predicts each result transaction from its own model of the bus sequencer and compares
// them in order. Depends on owbm_pkg.
module owbm_tick_checker #(
    parameter int COUNT_BITS = owbm_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [7:0]                      i_tx_byte,
    input  logic                            i_line_level,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            o_drive_low,
    input  logic                            o_busy_res,
    input  logic                            o_done_res,
    input  logic                            o_no_device,
    input  logic [7:0]                      o_rx_byte,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic                            o_cmd_active
);
    import owbm_pkg::*;

    t_cfg                  regs;
    t_phase                seq_phase;
    logic [COUNT_BITS-1:0] ticks;
    logic [2:0]            bit_pos;
    logic [7:0]            shifter;
    logic [7:0]            last_read;
    t_result               tick_results_due[$];
    int                    fail_total;

    // Counts one more tick of the current interval and tells whether it is over.
    function automatic logic interval_over(input int unsigned limit);
        int unsigned ceiling;
        ceiling = (1 << COUNT_BITS) - 1;
        if (limit > ceiling) limit = ceiling;
        if (ticks < ceiling) ticks = ticks + 1'b1;
        return ticks >= limit;
    endfunction

    function automatic void enter_phase(input t_phase next_phase);
        seq_phase = next_phase;
        ticks = '0;
    endfunction

    function automatic t_result bus_tick_outcome(input t_func cmd, input logic [7:0] tx,
                                                 input logic level);
        t_result r;
        logic    cur_bit;
        logic    finished;
        logic    absent;
        finished = 1'b0;
        absent = 1'b0;
        if (seq_phase == PH_IDLE && cmd != FUNC_NONE) begin
            bit_pos = '0;
            shifter = (cmd == FUNC_WRITE) ? tx : 8'h00;
            case (cmd)
                FUNC_RESET: enter_phase(PH_RST_LOW);
                FUNC_WRITE: enter_phase(PH_WR_LOW);
                default:    enter_phase(PH_RD_LOW);
            endcase
        end
        r.drive_low = seq_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
        cur_bit = shifter[bit_pos];
        case (seq_phase)
            PH_RST_LOW: begin
                if (interval_over(regs.reset_low_ticks)) enter_phase(PH_WAIT_LOW);
            end
            PH_WAIT_LOW: begin
                if (!level) begin
                    enter_phase(PH_WAIT_HIGH);
                end else if (interval_over(regs.presence_timeout)) begin
                    finished = 1'b1;
                    absent = 1'b1;
                end
            end
            PH_WAIT_HIGH: begin
                if (level) begin
                    finished = 1'b1;
                end else if (interval_over(regs.presence_timeout)) begin
                    finished = 1'b1;
                    absent = 1'b1;
                end
            end
            PH_WR_LOW: begin
                if (interval_over(cur_bit ? regs.short_pulse_ticks : regs.long_pulse_ticks))
                    enter_phase(PH_WR_REL);
            end
            PH_WR_REL: begin
                if (interval_over(cur_bit ? regs.long_pulse_ticks : regs.short_pulse_ticks)) begin
                    if (bit_pos == 3'd7) begin
                        finished = 1'b1;
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                        enter_phase(PH_WR_LOW);
                    end
                end
            end
            PH_RD_LOW: begin
                if (interval_over(regs.short_pulse_ticks)) enter_phase(PH_RD_WAIT);
            end
            PH_RD_WAIT: begin
                if (interval_over(regs.sample_delay_ticks)) begin
                    shifter[bit_pos] = shifter[bit_pos] | level;
                    enter_phase(PH_RD_REST);
                end
            end
            PH_RD_REST: begin
                if (interval_over(regs.long_pulse_ticks)) begin
                    if (bit_pos == 3'd7) begin
                        last_read = shifter;
                        finished = 1'b1;
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                        enter_phase(PH_RD_LOW);
                    end
                end
            end
            default: seq_phase = PH_IDLE;
        endcase
        if (finished) begin
            enter_phase(PH_IDLE);
            bit_pos = '0;
        end
        r.busy_res = (seq_phase != PH_IDLE);
        r.done_res = finished;
        r.no_device = absent;
        r.rx_byte = last_read;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            regs = {RESET_LOW_DEF, PRES_TMO_DEF, SHORT_PULSE_DEF, LONG_PULSE_DEF, SAMPLE_DLY_DEF};
            seq_phase = PH_IDLE;
            ticks = '0;
            bit_pos = '0;
            shifter = '0;
            last_read = '0;
            tick_results_due.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_RESET_LOW:   regs.reset_low_ticks = i_cfg_data[9:0];
                    REG_PRES_TMO:    regs.presence_timeout = i_cfg_data[9:0];
                    REG_SHORT_PULSE: regs.short_pulse_ticks = i_cfg_data[3:0];
                    REG_LONG_PULSE:  regs.long_pulse_ticks = i_cfg_data[6:0];
                    REG_SAMPLE_DLY:  regs.sample_delay_ticks = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                tick_results_due.push_back(bus_tick_outcome(t_func'(i_func), i_tx_byte,
                                                            i_line_level));
            if (o_out_valid && i_out_ready) begin
                got = {o_drive_low, o_busy_res, o_done_res, o_no_device, o_rx_byte};
                if (tick_results_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("Result transaction with none expected: drive=%0b busy=%0b",
                                 got.drive_low, got.busy_res, " done=%0b nodev=%0b rx=%02h",
                                 got.done_res, got.no_device, got.rx_byte);
                end else begin
                    want = tick_results_due.pop_front();
                    if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res || got.no_device !== want.no_device ||
                        got.rx_byte !== want.rx_byte) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("Mismatch at %0t: expected drive=%0b busy=%0b done=%0b",
                                     $realtime, want.drive_low, want.busy_res, want.done_res,
                                     " nodev=%0b rx=%02h, got drive=%0b busy=%0b done=%0b",
                                     want.no_device, want.rx_byte, got.drive_low,
                                     got.busy_res, got.done_res,
                                     " nodev=%0b rx=%02h", got.no_device, got.rx_byte);
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= tick_results_due.size();
        o_cmd_active <= (seq_phase != PH_IDLE);
    end

endmodule

>>> verif/one_wire_bus_master_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the one-wire bus master: clock, reset, tick and register stimulus.
// Depends on owbm_pkg, one_wire_bus_master_unit and owbm_tick_checker.
module one_wire_bus_master_unit_tb;
    import owbm_pkg::*;

    localparam int STALL_CYCLES  = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 1400;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_func = FUNC_NONE;
    logic [7:0]            i_tx_byte = 8'h00;
    logic                  i_line_level = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_drive_low;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_no_device;
    logic [7:0]            o_rx_byte;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int   fail_count;
    int   pending;
    logic cmd_active;
    int   quiet_cycles = 0;
    int   items_sent = 0;
    bit   idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    bit   stall_req = 1'b0;
    logic line_now = 1'b1;

    always #10 i_clk = ~i_clk;

    one_wire_bus_master_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_tx_byte    (i_tx_byte),
        .i_line_level (i_line_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_drive_low  (o_drive_low),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_no_device  (o_no_device),
        .o_rx_byte    (o_rx_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    owbm_tick_checker tick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_tx_byte    (i_tx_byte),
        .i_line_level (i_line_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_drive_low  (o_drive_low),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_no_device  (o_no_device),
        .o_rx_byte    (o_rx_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_cmd_active (cmd_active)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The result side holds off for a long stretch whenever the stimulus asks for it.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 11);
        end
    end

    function automatic logic bus_level_walk();
        if ($urandom_range(0, 7) == 0) line_now = ~line_now;
        return line_now;
    endfunction

    task automatic send_tick(input t_func cmd, input logic [7:0] tx, input logic level);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= cmd;
        i_tx_byte <= tx;
        i_line_level <= level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent = items_sent + 1;
    endtask

    // The command state seen here lags one transaction behind, so one extra idle tick may go.
    task automatic finish_command(input bit steady_high);
        do begin
            send_tick(FUNC_NONE, 8'($urandom), steady_high ? 1'b1 : bus_level_walk());
        end while (cmd_active);
    endtask

    task automatic pause_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        pause_input();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [9:0] rl, input logic [9:0] pt, input logic [9:0] sp,
                              input logic [9:0] lp, input logic [9:0] sd);
        write_reg(REG_RESET_LOW, rl);
        write_reg(REG_PRES_TMO, pt);
        write_reg(REG_SHORT_PULSE, sp);
        write_reg(REG_LONG_PULSE, lp);
        write_reg(REG_SAMPLE_DLY, sd);
        write_reg(REG_SPARE, 10'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int         phase_idx;
        int         phase_len;
        t_func      cmd;
        bit         big;
        logic [9:0] rl;
        logic [9:0] pt;
        logic [9:0] sp;
        logic [9:0] lp;
        logic [9:0] sd;
        phase_idx = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register values after reset: a bus reset answered by a presence pulse.
        send_tick(FUNC_RESET, 8'h00, 1'b1);
        repeat (483) send_tick(FUNC_NONE, 8'($urandom), 1'b1);
        repeat (40) send_tick(FUNC_NONE, 8'($urandom), 1'b0);
        finish_command(1'b1);
        settle();

        // Shortest intervals: every way a bus reset can end, writes, reads, ignored commands.
        set_config(10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        send_tick(FUNC_RESET, 8'hFF, 1'b1);
        send_tick(FUNC_NONE, 8'h00, 1'b1);
        send_tick(FUNC_RESET, 8'h00, 1'b1);
        send_tick(FUNC_NONE, 8'h00, 1'b0);
        send_tick(FUNC_NONE, 8'h00, 1'b1);
        send_tick(FUNC_RESET, 8'h00, 1'b1);
        send_tick(FUNC_NONE, 8'h00, 1'b0);
        send_tick(FUNC_NONE, 8'h00, 1'b0);
        send_tick(FUNC_WRITE, 8'hFF, 1'b1);
        send_tick(FUNC_READ, 8'h00, 1'b0);
        send_tick(FUNC_RESET, 8'hFF, 1'b1);
        finish_command(1'b1);
        send_tick(FUNC_WRITE, 8'h00, 1'b0);
        finish_command(1'b0);
        send_tick(FUNC_NONE, 8'hFF, 1'b0);
        send_tick(FUNC_READ, 8'hFF, 1'b0);
        finish_command(1'b0);
        settle();

        // Zero-length intervals behave as one tick.
        set_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_tick(FUNC_RESET, 8'h00, 1'b1);
        finish_command(1'b1);
        send_tick(FUNC_READ, 8'h00, 1'b0);
        finish_command(1'b0);
        send_tick(FUNC_WRITE, 8'h81, 1'b1);
        finish_command(1'b0);
        settle();

        while (items_sent < ITEM_TARGET) begin
            big = ($urandom_range(0, 5) == 0);
            rl = big ? 10'($urandom_range(0, 200)) : 10'($urandom_range(0, 12));
            pt = big ? 10'($urandom_range(0, 200)) : 10'($urandom_range(0, 12));
            sp = 10'($urandom_range(0, big ? 15 : 4));
            lp = 10'($urandom_range(0, big ? 127 : 10));
            sd = 10'($urandom_range(0, big ? 63 : 8));
            set_config(rl, pt, sp | (10'($urandom) << 4), lp | (10'($urandom) << 7),
                       sd | (10'($urandom) << 6));
            idle_on = (phase_idx != 2);
            rx_idle_on = idle_on;
            phase_len = $urandom_range(60, 120);
            for (int k = 0; k < phase_len; k++) begin
                cmd = ($urandom_range(0, 9) == 0) ? t_func'(2'($urandom_range(1, 3))) : FUNC_NONE;
                send_tick(cmd, 8'($urandom), bus_level_walk());
                if ((phase_idx == 1 && k == 30) || $urandom_range(0, 399) == 0)
                    stall_req = 1'b1;
                if ($urandom_range(0, 199) == 0)
                    pause_input();
            end
            finish_command(1'b0);
            settle();
            phase_idx++;
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_cfg.sv
hw/rtl/owbm_core.sv
hw/rtl/one_wire_bus_master_unit.sv
verif/owbm_tick_checker.sv
verif/one_wire_bus_master_unit_tb.sv
